// ===== rtl/sta_pkg.sv =====
// Shared widths, codes and reset constants of the sparse tile address translator.
`default_nettype none

package sta_pkg;

    // Default values of the top-level parameters
    localparam int MAX_TILES_DEFAULT   = 4096;
    localparam int OFFSET_BITS_DEFAULT = 48;

    // Channel field widths
    localparam int OPCODE_W = 2;
    localparam int COORD_W  = 16;
    localparam int STATUS_W = 2;
    localparam int OFFSET_W = 48;
    localparam int SLOT_W   = 12;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Register widths and ranges
    localparam int DIM_W        = 16;
    localparam int TILE_DIM_W   = 11;
    localparam int TILE_DIM_MAX = 1024;
    localparam int COUNT_W      = 4;
    localparam int COUNT_MAX    = 8;

    // Derived quantities
    localparam int INTILE_W     = TILE_DIM_W - 1;      // in-tile pixel position
    localparam int PB_W         = 7;                   // bytes per pixel, up to 64
    localparam int TB_W         = 27;                  // bytes per tile, up to 2^26
    localparam int DS_W         = 35;                  // header plus directory bytes
    localparam int PIX_LIN_W    = 21;                  // pixel index inside a tile
    localparam int PIX_OFF_W    = PIX_LIN_W + PB_W;    // byte offset inside a tile
    localparam int HEADER_BYTES = 24;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE_TILE = 2'd0,
        OP_READ_TILE  = 2'd1,
        OP_READ_PIXEL = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_RANGE  = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_TILE_WIDTH    = 3'd2,
        REG_TILE_HEIGHT   = 3'd3,
        REG_NUM_CHANNELS  = 3'd4,
        REG_CHANNEL_BYTES = 3'd5
    } cfg_index_t;

    // Register values after reset and what follows from them
    localparam int RST_IMAGE_WIDTH   = 1024;
    localparam int RST_IMAGE_HEIGHT  = 1024;
    localparam int RST_TILE_WIDTH    = 64;
    localparam int RST_TILE_HEIGHT   = 64;
    localparam int RST_NUM_CHANNELS  = 1;
    localparam int RST_CHANNEL_BYTES = 1;

    localparam int RST_TILES_ACROSS =
        (RST_IMAGE_WIDTH + RST_TILE_WIDTH - 1) / RST_TILE_WIDTH;
    localparam int RST_TILES_DOWN =
        (RST_IMAGE_HEIGHT + RST_TILE_HEIGHT - 1) / RST_TILE_HEIGHT;
    localparam int RST_PIXEL_BYTES = RST_NUM_CHANNELS * RST_CHANNEL_BYTES;
    localparam int RST_DATA_START  = HEADER_BYTES + 4 * RST_TILES_ACROSS * RST_TILES_DOWN;
    localparam int RST_TILE_BYTES  = RST_TILE_WIDTH * RST_TILE_HEIGHT * RST_PIXEL_BYTES;

endpackage

`default_nettype wire

// ===== rtl/sta_req_if.sv =====
// Request channel: opcode and coordinates with valid/ready.
`default_nettype none

interface sta_req_if;
    import sta_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [COORD_W-1:0]  coord_x;
    logic [COORD_W-1:0]  coord_y;

    modport source (output valid, output opcode, output coord_x, output coord_y,
                    input ready);
    modport sink   (input valid, input opcode, input coord_x, input coord_y,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/sta_rsp_if.sv =====
// Response channel: status, byte offset, slot and allocation flag with valid/ready.
`default_nettype none

interface sta_rsp_if;
    import sta_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] byte_offset;
    logic [SLOT_W-1:0]   slot;
    logic                newly_allocated;

    modport source (output valid, output status, output byte_offset, output slot,
                    output newly_allocated, input ready);
    modport sink   (input valid, input status, input byte_offset, input slot,
                    input newly_allocated, output ready);
endinterface

`default_nettype wire

// ===== rtl/sparse_tile_address_translator_core.sv =====
// Top level: tile directory memory, shared two-lane divider and address sequencer.
//
//  Channel   Dir   Handshake          Payload
//  req       in    valid/ready        opcode, coord_x, coord_y
//  rsp       out   valid/ready        status, byte_offset, slot, newly_allocated
//  cfg       in    cfg_we, no wait    cfg_index, cfg_wdata
//
//  A pixel op first runs the radix-2 divider that finds the tile column and row in
//  parallel; a tile op skips it. Absent tiles and grid or directory misses end sooner
//  than an access that finds or allocates its tile; accesses rejected at the input go
//  straight to the result. One access is in flight at a time. After reset the directory
//  memory is swept, one entry a cycle, with req.ready low. A register write sets off a
//  rederivation of the geometry before the next transfer. A stalled rsp holds the
//  finished result while the next request is taken.
`default_nettype none

module sparse_tile_address_translator_core #(
    parameter int MAX_TILES   = sta_pkg::MAX_TILES_DEFAULT,
    parameter int OFFSET_BITS = sta_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    sta_req_if.sink                        req,
    sta_rsp_if.source                      rsp,
    input  logic                           cfg_we,
    input  logic [sta_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sta_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import sta_pkg::*;

    localparam int AW        = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam int UW        = $clog2(MAX_TILES + 1);
    localparam int LW        = 2 * DIM_W + 1;
    localparam int GRID_W    = 2 * DIM_W;
    localparam int TWTH_W    = 2 * TILE_DIM_W;
    localparam int PROD_W    = AW + TB_W;
    localparam int WIDE_W    = (PROD_W > DS_W) ? PROD_W : DS_W;
    localparam int SUM_W     = WIDE_W + 2;
    localparam int KEEP_BITS = (OFFSET_BITS < OFFSET_W) ? OFFSET_BITS : OFFSET_W;
    localparam logic [OFFSET_W-1:0] OFF_MASK = {OFFSET_W{1'b1}} >> (OFFSET_W - KEEP_BITS);
    localparam int DVD_W     = DIM_W + 1;
    localparam int DV_STEPS  = DVD_W;
    localparam int DV_CNT_W  = $clog2(DV_STEPS);
    localparam int REM_W     = TILE_DIM_W;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DER_DIV,
        S_DER_MUL,
        S_DER_FIN,
        S_DIV,
        S_LIN,
        S_RD,
        S_CHK,
        S_OFF,
        S_SUM,
        S_DONE
    } state_t;

    state_t state_reg;
    logic   stale_reg;
    logic [AW-1:0] clr_addr_reg;

    // Configuration, stored already clamped
    logic [DIM_W-1:0]      img_w_reg;
    logic [DIM_W-1:0]      img_h_reg;
    logic [TILE_DIM_W-1:0] tile_w_reg;
    logic [TILE_DIM_W-1:0] tile_h_reg;
    logic [COUNT_W-1:0]    nchan_reg;
    logic [COUNT_W-1:0]    cbytes_reg;

    // Derived geometry
    logic [DIM_W-1:0]  ta_reg;
    logic [DIM_W-1:0]  td_reg;
    logic [DS_W-1:0]   ds_reg;
    logic [TB_W-1:0]   tb_reg;
    logic [PB_W-1:0]   pb_reg;
    logic [GRID_W-1:0] grid_reg;
    logic [TWTH_W-1:0] twth_reg;

    // Access in flight
    logic [OPCODE_W-1:0]  op_reg;
    logic [DIM_W-1:0]     tx_reg;
    logic [DIM_W-1:0]     ty_reg;
    logic [INTILE_W-1:0]  inx_reg;
    logic [INTILE_W-1:0]  iny_reg;
    logic [LW-1:0]        lin_reg;
    logic [PIX_LIN_W-1:0] pix_lin_reg;
    logic [PIX_OFF_W-1:0] pix_off_reg;
    logic [AW-1:0]        slot_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic                 fresh_reg;
    status_t              status_reg;
    logic [OFFSET_W-1:0]  offset_reg;
    logic [UW-1:0]        used_reg;

    // Output register
    logic                rsp_valid_reg;
    status_t             rsp_status_reg;
    logic [OFFSET_W-1:0] rsp_offset_reg;
    logic [SLOT_W-1:0]   rsp_slot_reg;
    logic                rsp_fresh_reg;

    // Divider lanes: lane 0 for columns, lane 1 for rows
    logic [DVD_W-1:0]      dv_num_reg  [2];
    logic [TILE_DIM_W-1:0] dv_den_reg  [2];
    logic [REM_W-1:0]      dv_rem_reg  [2];
    logic [DV_CNT_W-1:0]   dv_cnt_reg;
    logic [REM_W-1:0]      dv_shl      [2];
    logic                  dv_ge       [2];
    logic [DVD_W-1:0]      dv_num_next [2];
    logic [REM_W-1:0]      dv_rem_next [2];

    // Directory memory: valid bit over slot number
    logic [AW:0]   dir_mem [MAX_TILES];
    logic [AW:0]   dir_rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW:0]   mem_wdata;

    logic accept;
    logic out_free;
    logic px_in;
    logic dv_last;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v[DIM_W-1:0];
        if (r == '0) r = DIM_W'(1);
        return r;
    endfunction

    function automatic logic [TILE_DIM_W-1:0] clamp_tile(input logic [CFG_DATA_W-1:0] v);
        logic [TILE_DIM_W-1:0] r;
        r = v[TILE_DIM_W-1:0];
        if (r == '0) r = TILE_DIM_W'(1);
        else if (r > TILE_DIM_W'(TILE_DIM_MAX)) r = TILE_DIM_W'(TILE_DIM_MAX);
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] clamp_count(input logic [CFG_DATA_W-1:0] v);
        logic [COUNT_W-1:0] r;
        r = v[COUNT_W-1:0];
        if (r == '0) r = COUNT_W'(1);
        else if (r > COUNT_W'(COUNT_MAX)) r = COUNT_W'(COUNT_MAX);
        return r;
    endfunction

    assign req.ready = (state_reg == S_IDLE) && !stale_reg;
    assign accept    = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign px_in     = (req.coord_x < img_w_reg) && (req.coord_y < img_h_reg);
    assign dv_last   = (dv_cnt_reg == DV_CNT_W'(DV_STEPS - 1));

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = rsp_status_reg;
    assign rsp.byte_offset     = rsp_offset_reg;
    assign rsp.slot            = rsp_slot_reg;
    assign rsp.newly_allocated = rsp_fresh_reg;

    // One restoring step per cycle: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            dv_shl[i]      = {dv_rem_reg[i][REM_W-2:0], dv_num_reg[i][DVD_W-1]};
            dv_ge[i]       = (dv_shl[i] >= dv_den_reg[i]);
            dv_rem_next[i] = dv_ge[i] ? (dv_shl[i] - dv_den_reg[i]) : dv_shl[i];
            dv_num_next[i] = {dv_num_reg[i][DVD_W-2:0], dv_ge[i]};
        end
    end

    // Only one access is in flight, so the write in S_CHK always lands before the next read
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = (state_reg == S_CHK) && !dir_rdata_reg[AW] &&
                        (op_reg == OP_WRITE_TILE);
            mem_waddr = lin_reg[AW-1:0];
            mem_wdata = {1'b1, AW'(used_reg)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dir_mem[mem_waddr] <= mem_wdata;
        end
        dir_rdata_reg <= dir_mem[lin_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            stale_reg      <= 1'b0;
            clr_addr_reg   <= '0;
            img_w_reg      <= DIM_W'(RST_IMAGE_WIDTH);
            img_h_reg      <= DIM_W'(RST_IMAGE_HEIGHT);
            tile_w_reg     <= TILE_DIM_W'(RST_TILE_WIDTH);
            tile_h_reg     <= TILE_DIM_W'(RST_TILE_HEIGHT);
            nchan_reg      <= COUNT_W'(RST_NUM_CHANNELS);
            cbytes_reg     <= COUNT_W'(RST_CHANNEL_BYTES);
            ta_reg         <= DIM_W'(RST_TILES_ACROSS);
            td_reg         <= DIM_W'(RST_TILES_DOWN);
            ds_reg         <= DS_W'(RST_DATA_START);
            tb_reg         <= TB_W'(RST_TILE_BYTES);
            pb_reg         <= PB_W'(RST_PIXEL_BYTES);
            grid_reg       <= '0;
            twth_reg       <= '0;
            op_reg         <= '0;
            tx_reg         <= '0;
            ty_reg         <= '0;
            inx_reg        <= '0;
            iny_reg        <= '0;
            lin_reg        <= '0;
            pix_lin_reg    <= '0;
            pix_off_reg    <= '0;
            slot_reg       <= '0;
            prod_reg       <= '0;
            fresh_reg      <= 1'b0;
            status_reg     <= ST_RANGE;
            offset_reg     <= '0;
            used_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= ST_OK;
            rsp_offset_reg <= '0;
            rsp_slot_reg   <= '0;
            rsp_fresh_reg  <= 1'b0;
            dv_cnt_reg     <= '0;
            for (int i = 0; i < 2; i++)
            begin
                dv_num_reg[i] <= '0;
                dv_den_reg[i] <= '0;
                dv_rem_reg[i] <= '0;
            end
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == AW'(MAX_TILES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_IDLE:
                begin
                    if (stale_reg)
                    begin
                        // Tile counts are ceilings: divide size plus tile minus one
                        stale_reg     <= 1'b0;
                        dv_num_reg[0] <= DVD_W'(img_w_reg) + DVD_W'(tile_w_reg) - 1'b1;
                        dv_num_reg[1] <= DVD_W'(img_h_reg) + DVD_W'(tile_h_reg) - 1'b1;
                        dv_den_reg[0] <= tile_w_reg;
                        dv_den_reg[1] <= tile_h_reg;
                        dv_rem_reg[0] <= '0;
                        dv_rem_reg[1] <= '0;
                        dv_cnt_reg    <= '0;
                        state_reg     <= S_DER_DIV;
                    end
                    else if (accept)
                    begin
                        op_reg     <= req.opcode;
                        tx_reg     <= req.coord_x;
                        ty_reg     <= req.coord_y;
                        inx_reg    <= '0;
                        iny_reg    <= '0;
                        fresh_reg  <= 1'b0;
                        status_reg <= ST_RANGE;
                        if (req.opcode == OP_READ_PIXEL)
                        begin
                            if (px_in)
                            begin
                                dv_num_reg[0] <= DVD_W'(req.coord_x);
                                dv_num_reg[1] <= DVD_W'(req.coord_y);
                                dv_den_reg[0] <= tile_w_reg;
                                dv_den_reg[1] <= tile_h_reg;
                                dv_rem_reg[0] <= '0;
                                dv_rem_reg[1] <= '0;
                                dv_cnt_reg    <= '0;
                                state_reg     <= S_DIV;
                            end
                            else
                            begin
                                state_reg <= S_DONE;
                            end
                        end
                        else if (req.opcode == OP_WRITE_TILE || req.opcode == OP_READ_TILE)
                        begin
                            state_reg <= S_LIN;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end

                S_DER_DIV:
                begin
                    dv_num_reg <= dv_num_next;
                    dv_rem_reg <= dv_rem_next;
                    dv_cnt_reg <= dv_cnt_reg + 1'b1;
                    if (dv_last)
                    begin
                        ta_reg    <= dv_num_next[0][DIM_W-1:0];
                        td_reg    <= dv_num_next[1][DIM_W-1:0];
                        state_reg <= S_DER_MUL;
                    end
                end

                S_DER_MUL:
                begin
                    grid_reg  <= GRID_W'(ta_reg) * GRID_W'(td_reg);
                    twth_reg  <= TWTH_W'(tile_w_reg) * TWTH_W'(tile_h_reg);
                    pb_reg    <= PB_W'(PB_W'(nchan_reg) * PB_W'(cbytes_reg));
                    state_reg <= S_DER_FIN;
                end

                S_DER_FIN:
                begin
                    ds_reg    <= DS_W'({grid_reg, 2'b00}) + DS_W'(HEADER_BYTES);
                    tb_reg    <= TB_W'(TB_W'(twth_reg) * TB_W'(pb_reg));
                    state_reg <= S_IDLE;
                end

                S_DIV:
                begin
                    dv_num_reg <= dv_num_next;
                    dv_rem_reg <= dv_rem_next;
                    dv_cnt_reg <= dv_cnt_reg + 1'b1;
                    if (dv_last)
                    begin
                        // Quotient is the tile, remainder the pixel inside it
                        tx_reg    <= dv_num_next[0][DIM_W-1:0];
                        ty_reg    <= dv_num_next[1][DIM_W-1:0];
                        inx_reg   <= dv_rem_next[0][INTILE_W-1:0];
                        iny_reg   <= dv_rem_next[1][INTILE_W-1:0];
                        state_reg <= S_LIN;
                    end
                end

                S_LIN:
                begin
                    if (tx_reg >= ta_reg || ty_reg >= td_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        lin_reg   <= LW'(ty_reg) * LW'(ta_reg) + LW'(tx_reg);
                        state_reg <= S_RD;
                    end
                end

                S_RD:
                begin
                    pix_lin_reg <= PIX_LIN_W'(iny_reg) * PIX_LIN_W'(tile_w_reg) +
                                   PIX_LIN_W'(inx_reg);
                    if (lin_reg >= LW'(MAX_TILES))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_CHK;
                    end
                end

                S_CHK:
                begin
                    pix_off_reg <= PIX_OFF_W'(pix_lin_reg) * PIX_OFF_W'(pb_reg);
                    if (dir_rdata_reg[AW])
                    begin
                        slot_reg  <= dir_rdata_reg[AW-1:0];
                        state_reg <= S_OFF;
                    end
                    else if (op_reg == OP_WRITE_TILE)
                    begin
                        // First write to this tile: take the next free slot
                        slot_reg  <= AW'(used_reg);
                        used_reg  <= used_reg + 1'b1;
                        fresh_reg <= 1'b1;
                        state_reg <= S_OFF;
                    end
                    else
                    begin
                        status_reg <= ST_ABSENT;
                        state_reg  <= S_DONE;
                    end
                end

                S_OFF:
                begin
                    prod_reg  <= PROD_W'(slot_reg) * PROD_W'(tb_reg);
                    state_reg <= S_SUM;
                end

                S_SUM:
                begin
                    offset_reg <= OFF_MASK & OFFSET_W'(SUM_W'(ds_reg) + SUM_W'(prod_reg) +
                                  ((op_reg == OP_READ_PIXEL) ? SUM_W'(pix_off_reg) : '0));
                    status_reg <= ST_OK;
                    state_reg  <= S_DONE;
                end

                S_DONE:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        rsp_status_reg <= status_reg;
                        if (status_reg == ST_OK)
                        begin
                            rsp_offset_reg <= offset_reg;
                            rsp_slot_reg   <= SLOT_W'(slot_reg);
                            rsp_fresh_reg  <= fresh_reg;
                        end
                        else
                        begin
                            rsp_offset_reg <= '0;
                            rsp_slot_reg   <= '0;
                            rsp_fresh_reg  <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // A register write marks the geometry for rederivation
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:
                    begin
                        img_w_reg <= clamp_dim(cfg_wdata);
                        stale_reg <= 1'b1;
                    end
                    REG_IMAGE_HEIGHT:
                    begin
                        img_h_reg <= clamp_dim(cfg_wdata);
                        stale_reg <= 1'b1;
                    end
                    REG_TILE_WIDTH:
                    begin
                        tile_w_reg <= clamp_tile(cfg_wdata);
                        stale_reg  <= 1'b1;
                    end
                    REG_TILE_HEIGHT:
                    begin
                        tile_h_reg <= clamp_tile(cfg_wdata);
                        stale_reg  <= 1'b1;
                    end
                    REG_NUM_CHANNELS:
                    begin
                        nchan_reg <= clamp_count(cfg_wdata);
                        stale_reg <= 1'b1;
                    end
                    REG_CHANNEL_BYTES:
                    begin
                        cbytes_reg <= clamp_count(cfg_wdata);
                        stale_reg  <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    a_no_transfer_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !req.ready)
        else $error("request taken during directory sweep");

    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(MAX_TILES))
        else $error("slot count beyond directory size");

    a_alloc_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg != S_CLEAR) |->
            (op_reg == OP_WRITE_TILE && lin_reg < LW'(MAX_TILES)))
        else $error("directory written outside a valid tile write");

    a_alloc_advances_count: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == S_CHK) |=> (used_reg == UW'($past(used_reg) + 1'b1)))
        else $error("allocation did not advance the slot count");

    a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |->
            (rsp.byte_offset == '0 && rsp.slot == '0 && !rsp.newly_allocated))
        else $error("nonzero fields on a failed access");

endmodule

`default_nettype wire

// ===== tb/tb_sparse_tile_address_translator_core.sv =====
// Self-checking testbench: directed table plus random tile and pixel accesses under several settings.
module tb_sparse_tile_address_translator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import sta_pkg::*;

    localparam int          TILE_SLOTS   = MAX_TILES_DEFAULT;
    localparam int          WATCHDOG_MAX = 20000;
    localparam int          SETTLE       = 30;
    localparam int          NUM_PHASES   = 9;
    localparam int          PHASE_ITEMS  = 125;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam bit          ROW_REQ      = 1'b0;
    localparam bit          ROW_CFG      = 1'b1;

    typedef struct packed {
        status_t             status;
        logic [OFFSET_W-1:0] byte_offset;
        logic [SLOT_W-1:0]   slot;
        logic                newly_allocated;
    } lookup_t;

    // Request rows carry op, x, y; register rows carry sel and the value in b.
    typedef struct packed {
        bit                  kind;
        logic [1:0]          op;
        cfg_index_t          sel;
        logic [15:0]         a;
        logic [15:0]         b;
        bit                  typed;
        status_t             st;
        logic [OFFSET_W-1:0] off;
        logic [SLOT_W-1:0]   slot;
        logic                fresh;
    } plan_row_t;

    localparam int NUM_ROWS = 28;
    localparam plan_row_t DIRECTED [NUM_ROWS] = '{
        '{ROW_REQ, OP_READ_TILE,  REG_IMAGE_WIDTH, 16'd0,     16'd0,     1'b1, ST_ABSENT, 48'd0,     12'd0, 1'b0},
        '{ROW_REQ, OP_READ_PIXEL, REG_IMAGE_WIDTH, 16'd0,     16'd0,     1'b1, ST_ABSENT, 48'd0,     12'd0, 1'b0},
        '{ROW_REQ, OP_WRITE_TILE, REG_IMAGE_WIDTH, 16'd0,     16'd0,     1'b1, ST_OK,     48'd1048,  12'd0, 1'b1},
        '{ROW_REQ, OP_WRITE_TILE, REG_IMAGE_WIDTH, 16'd0,     16'd0,     1'b1, ST_OK,     48'd1048,  12'd0, 1'b0},
        '{ROW_REQ, OP_READ_TILE,  REG_IMAGE_WIDTH, 16'd0,     16'd0,     1'b1, ST_OK,     48'd1048,  12'd0, 1'b0},
        '{ROW_REQ, OP_WRITE_TILE, REG_IMAGE_WIDTH, 16'd15,    16'd15,    1'b1, ST_OK,     48'd5144,  12'd1, 1'b1},
        '{ROW_REQ, OP_READ_PIXEL, REG_IMAGE_WIDTH, 16'd1023,  16'd1023,  1'b1, ST_OK,     48'd9239,  12'd1, 1'b0},
        '{ROW_REQ, OP_READ_PIXEL, REG_IMAGE_WIDTH, 16'd65,    16'd1,     1'b1, ST_ABSENT, 48'd0,     12'd0, 1'b0},
        '{ROW_REQ, OP_WRITE_TILE, REG_IMAGE_WIDTH, 16'd16,    16'd0,     1'b1, ST_RANGE,  48'd0,     12'd0, 1'b0},
        '{ROW_REQ, OP_WRITE_TILE, REG_IMAGE_WIDTH, 16'd0,     16'd16,    1'b1, ST_RANGE,  48'd0,     12'd0, 1'b0},
        '{ROW_REQ, OP_READ_TILE,  REG_IMAGE_WIDTH, 16'd65535, 16'd65535, 1'b1, ST_RANGE,  48'd0,     12'd0, 1'b0},
        '{ROW_REQ, OP_READ_PIXEL, REG_IMAGE_WIDTH, 16'd1024,  16'd0,     1'b1, ST_RANGE,  48'd0,     12'd0, 1'b0},
        '{ROW_REQ, OP_READ_PIXEL, REG_IMAGE_WIDTH, 16'd0,     16'd1024,  1'b1, ST_RANGE,  48'd0,     12'd0, 1'b0},
        '{ROW_REQ, OP_READ_PIXEL, REG_IMAGE_WIDTH, 16'd65535, 16'd65535, 1'b1, ST_RANGE,  48'd0,     12'd0, 1'b0},
        '{ROW_REQ, OP_UNUSED,     REG_IMAGE_WIDTH, 16'd0,     16'd0,     1'b1, ST_RANGE,  48'd0,     12'd0, 1'b0},
        '{ROW_REQ, OP_UNUSED,     REG_IMAGE_WIDTH, 16'd65535, 16'd65535, 1'b1, ST_RANGE,  48'd0,     12'd0, 1'b0},
        '{ROW_REQ, OP_WRITE_TILE, REG_IMAGE_WIDTH, 16'd1,     16'd1,     1'b1, ST_OK,     48'd9240,  12'd2, 1'b1},
        '{ROW_REQ, OP_READ_PIXEL, REG_IMAGE_WIDTH, 16'd127,   16'd127,   1'b1, ST_OK,     48'd13335, 12'd2, 1'b0},
        // 8x16 tiles give a 128x64 grid, half of it past the directory
        '{ROW_CFG, OP_UNUSED,     REG_TILE_WIDTH,    16'd0,   16'd8,     1'b0, ST_OK,     48'd0,     12'd0, 1'b0},
        '{ROW_CFG, OP_UNUSED,     REG_TILE_HEIGHT,   16'd0,   16'd16,    1'b0, ST_OK,     48'd0,     12'd0, 1'b0},
        '{ROW_CFG, OP_UNUSED,     REG_NUM_CHANNELS,  16'd0,   16'd15,    1'b0, ST_OK,     48'd0,     12'd0, 1'b0},
        '{ROW_CFG, OP_UNUSED,     REG_CHANNEL_BYTES, 16'd0,   16'd0,     1'b0, ST_OK,     48'd0,     12'd0, 1'b0},
        '{ROW_REQ, OP_READ_TILE,  REG_IMAGE_WIDTH, 16'd0,     16'd0,     1'b0, ST_OK,     48'd0,     12'd0, 1'b0},
        '{ROW_REQ, OP_WRITE_TILE, REG_IMAGE_WIDTH, 16'd0,     16'd32,    1'b1, ST_RANGE,  48'd0,     12'd0, 1'b0},
        '{ROW_REQ, OP_WRITE_TILE, REG_IMAGE_WIDTH, 16'd127,   16'd31,    1'b0, ST_OK,     48'd0,     12'd0, 1'b0},
        '{ROW_REQ, OP_READ_PIXEL, REG_IMAGE_WIDTH, 16'd1023,  16'd511,   1'b0, ST_OK,     48'd0,     12'd0, 1'b0},
        '{ROW_REQ, OP_READ_TILE,  REG_IMAGE_WIDTH, 16'd1,     16'd1,     1'b0, ST_OK,     48'd0,     12'd0, 1'b0},
        '{ROW_REQ, OP_READ_TILE,  REG_IMAGE_WIDTH, 16'd17,    16'd0,     1'b0, ST_OK,     48'd0,     12'd0, 1'b0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    sta_req_if req_ch ();
    sta_rsp_if rsp_ch ();

    sparse_tile_address_translator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Translator state as the testbench tracks it
    int unsigned     reg_img_w, reg_img_h, reg_tile_w, reg_tile_h, reg_chans, reg_chan_bytes;
    int unsigned     img_w_eff, img_h_eff, tw_eff, th_eff, px_bytes;
    int unsigned     grid_across, grid_down;
    longint unsigned data_base, tile_size;
    bit              dir_valid [TILE_SLOTS];
    logic [SLOT_W-1:0] dir_slot [TILE_SLOTS];
    int unsigned     slots_used;

    lookup_t pending_lookups [$];
    int      errors;
    int      items_sent;
    int      settings_applied;
    int      status_seen [3];
    int      fresh_seen;
    int      quiet_cycles;
    bit      quiet_phase;

    function automatic int unsigned clamp_reg(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function void rederive();
        img_w_eff   = clamp_reg(reg_img_w, 1, 65535);
        img_h_eff   = clamp_reg(reg_img_h, 1, 65535);
        tw_eff      = clamp_reg(reg_tile_w, 1, TILE_DIM_MAX);
        th_eff      = clamp_reg(reg_tile_h, 1, TILE_DIM_MAX);
        px_bytes    = clamp_reg(reg_chans, 1, COUNT_MAX) * clamp_reg(reg_chan_bytes, 1, COUNT_MAX);
        grid_across = (img_w_eff + tw_eff - 1) / tw_eff;
        grid_down   = (img_h_eff + th_eff - 1) / th_eff;
        data_base   = 64'(HEADER_BYTES) + 64'(grid_across) * 64'(grid_down) * 64'd4;
        tile_size   = 64'(tw_eff) * 64'(th_eff) * 64'(px_bytes);
    endfunction

    function void set_register(cfg_index_t idx, logic [15:0] val);
        case (idx)
            REG_IMAGE_WIDTH:   reg_img_w      = val;
            REG_IMAGE_HEIGHT:  reg_img_h      = val;
            REG_TILE_WIDTH:    reg_tile_w     = val[TILE_DIM_W-1:0];
            REG_TILE_HEIGHT:   reg_tile_h     = val[TILE_DIM_W-1:0];
            REG_NUM_CHANNELS:  reg_chans      = val[COUNT_W-1:0];
            REG_CHANNEL_BYTES: reg_chan_bytes = val[COUNT_W-1:0];
            default: ;
        endcase
        rederive();
    endfunction

    // Work out the result of one access and update the directory as the block would
    function automatic lookup_t translate(logic [1:0] op, logic [15:0] x, logic [15:0] y);
        lookup_t         r;
        int unsigned     tx, ty, inx, iny;
        longint unsigned lin, off;
        r        = '0;
        r.status = ST_RANGE;
        inx      = 0;
        iny      = 0;
        if (op == OP_UNUSED)
            return r;
        if (op == OP_READ_PIXEL) begin
            if (x >= img_w_eff || y >= img_h_eff)
                return r;
            tx  = x / tw_eff;
            ty  = y / th_eff;
            inx = x - tx * tw_eff;
            iny = y - ty * th_eff;
        end else begin
            tx = x;
            ty = y;
        end
        if (tx >= grid_across || ty >= grid_down)
            return r;
        lin = 64'(ty) * 64'(grid_across) + 64'(tx);
        if (lin >= TILE_SLOTS)
            return r;
        if (!dir_valid[lin]) begin
            if (op != OP_WRITE_TILE) begin
                r.status = ST_ABSENT;
                return r;
            end
            dir_valid[lin]    = 1'b1;
            dir_slot[lin]     = slots_used[SLOT_W-1:0];
            slots_used++;
            r.newly_allocated = 1'b1;
        end
        off = data_base + 64'(dir_slot[lin]) * tile_size;
        if (op == OP_READ_PIXEL)
            off += (64'(iny) * 64'(tw_eff) + 64'(inx)) * 64'(px_bytes);
        r.status      = ST_OK;
        r.byte_offset = off[OFFSET_W-1:0];
        r.slot        = dir_slot[lin];
        return r;
    endfunction

    // Mostly short gaps, now and then a long one
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function logic [15:0] pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 16'($urandom_range(1, 1200));
        if (r < 90)
            return 16'($urandom_range(1, 65535));
        return 16'($urandom);
    endfunction

    function logic [15:0] pick_tile();
        if ($urandom_range(0, 99) < 70)
            return 16'($urandom_range(1, 96));
        return 16'($urandom_range(0, 2047));
    endfunction

    task report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        errors++;
    endtask

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_MAX);
            $display("sparse_tile_address_translator_core regression: fail");
            $finish;
        end
    end

    // Compare each result transfer against the oldest pending lookup
    always @(posedge clk) begin
        lookup_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_lookups.size() == 0) begin
                report_mismatch("result with nothing pending, status", rsp_ch.status, 0);
            end else begin
                want = pending_lookups.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", rsp_ch.status, want.status);
                if (rsp_ch.byte_offset !== want.byte_offset)
                    report_mismatch("byte_offset", rsp_ch.byte_offset, want.byte_offset);
                if (rsp_ch.slot !== want.slot)
                    report_mismatch("slot", rsp_ch.slot, want.slot);
                if (rsp_ch.newly_allocated !== want.newly_allocated)
                    report_mismatch("newly_allocated", rsp_ch.newly_allocated,
                                    want.newly_allocated);
                if (want.status <= ST_RANGE)
                    status_seen[want.status]++;
                if (want.newly_allocated)
                    fresh_seen++;
            end
        end
    end

    // Result side: random stalls, steady in quiet phases
    initial begin
        int stall;
        int run;
        rsp_ch.ready = 1'b0;
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                @(negedge clk);
                rsp_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            rsp_ch.ready <= 1'b1;
            run = $urandom_range(1, 8);
            repeat (run - 1) @(negedge clk);
        end
    end

    task send_item(input logic [1:0] op, input logic [15:0] x, input logic [15:0] y,
                   input bit typed, input lookup_t typed_res);
        int      gap;
        lookup_t want;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid   <= 1'b1;
        req_ch.opcode  <= op;
        req_ch.coord_x <= x;
        req_ch.coord_y <= y;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        want = translate(op, x, y);
        if (typed)
            want = typed_res;
        pending_lookups.push_back(want);
        items_sent++;
    endtask

    // Drop the request, let every pending result come back, then hold a while
    task settle_idle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task write_register(input cfg_index_t idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        set_register(idx, val);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task apply_setting(input logic [15:0] w, input logic [15:0] h, input logic [15:0] tw,
                       input logic [15:0] th, input logic [15:0] nc, input logic [15:0] cb);
        settle_idle();
        write_register(REG_IMAGE_WIDTH, w);
        write_register(REG_IMAGE_HEIGHT, h);
        write_register(REG_TILE_WIDTH, tw);
        write_register(REG_TILE_HEIGHT, th);
        write_register(REG_NUM_CHANNELS, nc);
        write_register(REG_CHANNEL_BYTES, cb);
        settings_applied++;
    endtask

    // Mostly in-grid, in-directory accesses; some edge and noise items
    task make_item(output logic [1:0] op, output logic [15:0] x, output logic [15:0] y);
        int          r;
        int unsigned span_x, rows, lim_x, lim_y;
        r      = $urandom_range(0, 99);
        span_x = (grid_across < TILE_SLOTS) ? grid_across : TILE_SLOTS;
        rows   = (TILE_SLOTS + grid_across - 1) / grid_across;
        rows   = (rows < grid_down) ? rows : grid_down;
        if (r < 6) begin
            op = 2'($urandom_range(0, 3));
            x  = 16'($urandom);
            y  = 16'($urandom);
            return;
        end
        op = (r < 45) ? OP_WRITE_TILE : (r < 65) ? OP_READ_TILE : OP_READ_PIXEL;
        if (op != OP_READ_PIXEL) begin
            if ($urandom_range(0, 9) == 0) begin
                lim_x = (grid_across < 65535) ? grid_across : 65535;
                lim_y = (grid_down < 65535) ? grid_down : 65535;
            end else begin
                lim_x = span_x - 1;
                lim_y = rows - 1;
            end
        end else begin
            if ($urandom_range(0, 9) == 0) begin
                lim_x = img_w_eff;
                lim_y = img_h_eff;
            end else begin
                lim_x = ((span_x * tw_eff < img_w_eff) ? span_x * tw_eff : img_w_eff) - 1;
                lim_y = ((rows * th_eff < img_h_eff) ? rows * th_eff : img_h_eff) - 1;
            end
        end
        x = 16'($urandom_range(0, lim_x));
        y = 16'($urandom_range(0, lim_y));
    endtask

    initial begin
        plan_row_t   row;
        lookup_t     typed_res;
        logic [1:0]  op;
        logic [15:0] x, y;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        req_ch.valid   = 1'b0;
        req_ch.opcode  = '0;
        req_ch.coord_x = '0;
        req_ch.coord_y = '0;
        quiet_phase    = 1'b0;
        errors         = 0;
        items_sent     = 0;
        fresh_seen     = 0;
        quiet_cycles   = 0;
        slots_used     = 0;
        settings_applied = 1;
        status_seen    = '{0, 0, 0};
        reg_img_w      = RST_IMAGE_WIDTH;
        reg_img_h      = RST_IMAGE_HEIGHT;
        reg_tile_w     = RST_TILE_WIDTH;
        reg_tile_h     = RST_TILE_HEIGHT;
        reg_chans      = RST_NUM_CHANNELS;
        reg_chan_bytes = RST_CHANNEL_BYTES;
        rederive();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table; the directory sweep after reset holds off the first transfer
        for (int i = 0; i < NUM_ROWS; i++) begin
            row = DIRECTED[i];
            if (row.kind == ROW_CFG) begin
                settle_idle();
                write_register(row.sel, row.b);
            end else begin
                typed_res                 = '0;
                typed_res.status          = row.st;
                typed_res.byte_offset     = row.off;
                typed_res.slot            = row.slot;
                typed_res.newly_allocated = row.fresh;
                send_item(row.op, row.a, row.b, row.typed, typed_res);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
                1: apply_setting(16'd65535, 16'd65535, 16'd2047, 16'd2047, 16'd15, 16'd15);
                2: apply_setting(16'd65535, 16'd65535, 16'd0, 16'd0, 16'd8, 16'd8);
                3: apply_setting(16'd1, 16'd65535, 16'd1024, 16'd1, 16'd1, 16'd8);
                default: apply_setting(pick_dim(), pick_dim(), pick_tile(), pick_tile(),
                                       16'($urandom_range(0, 15)), 16'($urandom_range(0, 15)));
            endcase
            quiet_phase = (p % 3 == 2);
            repeat (PHASE_ITEMS) begin
                make_item(op, x, y);
                send_item(op, x, y, 1'b0, '0);
            end
            quiet_phase = 1'b0;
        end

        settle_idle();

        $display("covered %0d requests over %0d register settings, %0d slots allocated",
                 items_sent, settings_applied, fresh_seen);
        $display("results: %0d ok, %0d absent, %0d out of range",
                 status_seen[ST_OK], status_seen[ST_ABSENT], status_seen[ST_RANGE]);
        if (errors == 0 && pending_lookups.size() == 0)
            $display("sparse_tile_address_translator_core regression: pass");
        else
            $display("sparse_tile_address_translator_core regression: fail");
        $finish;
    end

endmodule
